FILE: design/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and character codes for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam int unsigned IDX_W = 3;
  localparam int unsigned CPOS_W = 5;
  localparam int unsigned CNT_W = 4;

  typedef struct packed {
    logic in_params;
    logic comma_seen;
    logic in_token;
    logic had_param_input;
    logic error_latched;
    logic overflow_latched;
  } flags_t;

  typedef struct packed {
    logic              store_valid;
    logic [7:0]        store_char;
    logic [IDX_W-1:0]  token_index;
    logic [CPOS_W-1:0] char_pos;
    logic              token_end;
    logic              line_end;
    logic              syntax_error;
    logic [CNT_W-1:0]  token_count;
    logic              overflow;
  } result_t;

endpackage

FILE: design/clt_step.sv
// ----------------------------------------------------------------------------
// clt_step
// Next parser state and result word for one character.
// ----------------------------------------------------------------------------
module clt_step #(
  parameter int unsigned MAX_TOKENS    = 8,
  parameter int unsigned MAX_TOKEN_LEN = 32,
  parameter int unsigned TD_W          = $clog2(MAX_TOKENS + 1),
  parameter int unsigned POS_W         = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  logic [7:0]       ch,
  input  clt_pkg::flags_t  flags,
  input  logic [TD_W-1:0]  tokens_done,
  input  logic [POS_W-1:0] pos_in_token,
  output clt_pkg::flags_t  flags_nxt,
  output logic [TD_W-1:0]  tokens_done_nxt,
  output logic [POS_W-1:0] pos_in_token_nxt,
  output clt_pkg::result_t res
);

  localparam logic [TD_W-1:0]  TD_MAX  = TD_W'(MAX_TOKENS);
  localparam logic [TD_W-1:0]  TD_LAST = TD_W'(MAX_TOKENS - 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TOKEN_LEN);

  logic             eol;
  logic             blank;
  logic             is_comma;
  logic             do_put;
  logic             do_finish;
  logic             do_error;
  clt_pkg::flags_t  f;
  logic [TD_W-1:0]  td;
  logic [POS_W-1:0] p;

  assign eol      = (ch == clt_pkg::CH_NUL);
  assign blank    = eol || (ch == clt_pkg::CH_SPACE) || (ch == clt_pkg::CH_TAB);
  assign is_comma = (ch == clt_pkg::CH_COMMA);

  always_comb begin
    f         = flags;
    td        = tokens_done;
    p         = pos_in_token;
    do_put    = 1'b0;
    do_finish = 1'b0;
    do_error  = 1'b0;

    res              = '0;
    res.line_end     = eol;
    res.token_index  = (tokens_done < TD_MAX) ? clt_pkg::IDX_W'(tokens_done)
                                              : clt_pkg::IDX_W'(TD_LAST);

    if (!flags.error_latched) begin
      if (!flags.in_params) begin
        if (!blank) begin
          do_put = 1'b1;
        end else if (flags.in_token) begin
          do_finish    = 1'b1;
          f.in_params  = 1'b1;
          f.comma_seen = 1'b1;
        end
      end else if (flags.comma_seen) begin
        if (!blank) begin
          f.had_param_input = 1'b1;
          if (is_comma) begin
            if (!flags.in_token) begin
              do_error = 1'b1;
            end else begin
              do_finish = 1'b1;
            end
          end else begin
            do_put = 1'b1;
          end
        end else if (flags.in_token) begin
          do_finish    = 1'b1;
          f.comma_seen = 1'b0;
        end
      end else if (!blank) begin
        if (is_comma) begin
          f.comma_seen = 1'b1;
        end else begin
          do_error = 1'b1;
        end
      end
      if (eol && f.comma_seen && f.had_param_input) begin
        do_error = 1'b1;
      end
    end

    if (do_put) begin
      f.in_token = 1'b1;
      if ((tokens_done >= TD_MAX) || (pos_in_token >= POS_MAX)) begin
        f.overflow_latched = 1'b1;
      end else begin
        res.store_valid = 1'b1;
        res.store_char  = ch;
        res.token_index = clt_pkg::IDX_W'(tokens_done);
        res.char_pos    = clt_pkg::CPOS_W'(pos_in_token);
        p               = pos_in_token + POS_W'(1);
      end
    end

    if (do_finish) begin
      if (tokens_done < TD_MAX) begin
        res.token_end   = 1'b1;
        res.token_index = clt_pkg::IDX_W'(tokens_done);
        td              = tokens_done + TD_W'(1);
      end
      p          = '0;
      f.in_token = 1'b0;
    end

    if (do_error) begin
      f.error_latched = 1'b1;
      f.in_token      = 1'b0;
      td              = '0;
      p               = '0;
    end

    res.syntax_error = f.error_latched;
    res.token_count  = clt_pkg::CNT_W'(td);
    res.overflow     = f.overflow_latched;

    if (eol) begin
      flags_nxt        = '0;
      tokens_done_nxt  = '0;
      pos_in_token_nxt = '0;
    end else begin
      flags_nxt        = f;
      tokens_done_nxt  = td;
      pos_in_token_nxt = p;
    end
  end

endmodule

FILE: design/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a command line into a command word and comma separated parameters,
// streaming each stored character with its token index and position.
// ----------------------------------------------------------------------------
// Path: the input register loads at acceptance; the result register loads from
//   it when the output is not stalled, and out_valid rises with it.
// Throughput: one word per cycle while out_stall is low; the parser state registers load with each result.
// Reset: clears the parser state and empties both register stages.
module command_line_tokenizer #(
  parameter int unsigned MAX_TOKENS    = 8,
  parameter int unsigned MAX_TOKEN_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_store_valid,
  output logic [7:0] out_store_char,
  output logic [2:0] out_token_index,
  output logic [4:0] out_char_pos,
  output logic       out_token_end,
  output logic       out_line_end,
  output logic       out_syntax_error,
  output logic [3:0] out_token_count,
  output logic       out_overflow
);

  localparam int unsigned TD_W  = $clog2(MAX_TOKENS + 1);
  localparam int unsigned POS_W = $clog2(MAX_TOKEN_LEN + 1);

  logic             in_valid_r;
  logic [7:0]       in_ch_r;
  logic             out_valid_r;
  clt_pkg::result_t res_r;
  clt_pkg::result_t res_nxt;

  clt_pkg::flags_t  flags_r;
  clt_pkg::flags_t  flags_nxt;
  logic [TD_W-1:0]  tokens_done_r;
  logic [TD_W-1:0]  tokens_done_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;

  logic out_load;
  logic step;

  assign out_load = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_load;
  assign in_stall = in_valid_r && !out_load;

  clt_step #(
    .MAX_TOKENS    (MAX_TOKENS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .TD_W          (TD_W),
    .POS_W         (POS_W)
  ) u_step (
    .ch               (in_ch_r),
    .flags            (flags_r),
    .tokens_done      (tokens_done_r),
    .pos_in_token     (pos_r),
    .flags_nxt        (flags_nxt),
    .tokens_done_nxt  (tokens_done_nxt),
    .pos_in_token_nxt (pos_nxt),
    .res              (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      flags_r       <= '0;
      tokens_done_r <= '0;
      pos_r         <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= in_valid_r;
      end
      if (step) begin
        flags_r       <= flags_nxt;
        tokens_done_r <= tokens_done_nxt;
        pos_r         <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_ch_r <= in_ch;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_store_valid  = res_r.store_valid;
  assign out_store_char   = res_r.store_char;
  assign out_token_index  = res_r.token_index;
  assign out_char_pos     = res_r.char_pos;
  assign out_token_end    = res_r.token_end;
  assign out_line_end     = res_r.line_end;
  assign out_syntax_error = res_r.syntax_error;
  assign out_token_count  = res_r.token_count;
  assign out_overflow     = res_r.overflow;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    tokens_done_r <= TD_W'(MAX_TOKENS))
    else $error("token count beyond limit");

  a_pos_bound : assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_TOKEN_LEN))
    else $error("token position beyond limit");

  a_error_clears : assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.error_latched |-> (tokens_done_r == '0 && !flags_r.in_token))
    else $error("error left tokens pending");

  a_store_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_valid |-> !out_syntax_error && !out_line_end)
    else $error("stored character on error or line end");

  a_eol_resets : assert property (@(posedge clk) disable iff (!rst_n)
    step && res_nxt.line_end |=> flags_r == '0 && tokens_done_r == '0 && pos_r == '0)
    else $error("state not cleared after line end");

endmodule
